// ----- design/tls_vector_schema_validator_core_defines.svh -----
// Assertion macros shared by the schema validator RTL.
`ifndef TLS_VECTOR_SCHEMA_VALIDATOR_CORE_DEFINES_SVH
`define TLS_VECTOR_SCHEMA_VALIDATOR_CORE_DEFINES_SVH

// Combinational implication, checked at every clock edge out of reset.
`define TVSV_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Implication into the following clock edge.
`define TVSV_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- design/tvsv_pkg.sv -----
// Types and constants for the schema validator.
package tvsv_pkg;

    localparam int MAX_PREFIX_BYTES = 4;
    localparam int SET_BYTES        = 2;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_DATA    = 2'd1,
        REQ_RESTART = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        KIND_CONST  = 2'd0,
        KIND_INT    = 2'd1,
        KIND_PREFIX = 2'd2,
        KIND_FIXED  = 2'd3
    } kind_code_t;

    typedef enum logic [1:0] {
        VERD_PENDING = 2'd0,
        VERD_VALID   = 2'd1,
        VERD_STUCK   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [3:0]  slot;
        logic [1:0]  kind;
        logic [7:0]  size_bytes;
        logic [31:0] bound_low;
        logic [32:0] bound_high;
        logic [15:0] match_first;
        logic [15:0] match_second;
        logic [1:0]  match_count;
    } req_word_t;

    typedef struct packed {
        logic       complete;
        logic       stuck;
        logic [3:0] field_now;
    } rsp_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  size_bytes;
        logic [31:0] bound_low;
        logic [32:0] bound_high;
        logic [15:0] match_first;
        logic [15:0] match_second;
        logic [1:0]  match_count;
    } desc_t;

    // Byte k (counted from the least significant end) of a constant; bytes
    // above the stored width read as zero.
    function automatic logic [7:0] const_byte(input logic [15:0] v, input logic [7:0] k);
        logic [7:0] res;
        if (k >= 8'(SET_BYTES))
        begin
            res = 8'd0;
        end
        else
        begin
            res = 8'(v >> {k[1:0], 3'b000});
        end
        return res;
    endfunction

endpackage

// ----- design/tls_vector_schema_validator_core.sv -----
// An accepted word is held in stage 1; its result word is then registered and held until taken.
// Throughput: one word per cycle while rsp_ready takes results; the descriptor memory is read on
//   two ports (current field and the one after it) at acceptance, so a field change never stalls.
// Reset: parse position, counters and sticky stuck flag cleared, field_total set to 1.
// The descriptor memory is not cleared; each slot must be loaded before a byte reaches it.
module tls_vector_schema_validator_core #(
    parameter int MAX_FIELDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  tvsv_pkg::req_word_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output tvsv_pkg::rsp_word_t  rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import tvsv_pkg::*;

    `include "tls_vector_schema_validator_core_defines.svh"

    localparam int PW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int TW    = PW + 1;
    localparam int DEPTH = 1 << PW;

    // Config register
    logic [4:0]    field_total_reg;

    // Descriptor memory and its read registers
    desc_t         desc_mem [DEPTH];
    desc_t         rd_a_reg;
    desc_t         rd_b_reg;
    logic          sel_b_reg;
    logic [PW-1:0] rd_a_addr;
    logic [PW-1:0] rd_b_addr;
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    desc_t         mem_wdata;

    // Pipeline
    logic          s1_valid_reg;
    req_word_t     s1_req_reg;
    logic          rsp_valid_reg;
    rsp_word_t     rsp_reg;
    logic          s1_adv;
    logic          s1_fire;
    logic          req_fire;

    // Parse state
    logic [PW-1:0] field_pos_reg,    field_pos_next;
    logic [7:0]    head_count_reg,   head_count_next;
    logic [31:0]   head_value_reg,   head_value_next;
    logic          length_known_reg, length_known_next;
    logic [32:0]   body_count_reg,   body_count_next;
    logic          stuck_reg,        stuck_next;

    // Field step
    desc_t         cur;
    logic [7:0]    sz;
    logic [TW-1:0] total_eff;
    logic [PW-1:0] last_pos;
    verdict_t      verdict;
    logic          done;
    logic [1:0]    alive;
    logic [7:0]    cb_k;
    logic [31:0]   hv_new;
    logic [7:0]    hc_inc;
    logic [1:0]    shb;
    logic [56:0]   mn;
    logic [56:0]   mx;
    verdict_t      hdr_verdict;

    // ---------------- handshake ----------------
    assign s1_adv    = !rsp_valid_reg || rsp_ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {27'd0, field_total_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_total_reg <= 5'd1;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            field_total_reg <= pwdata[4:0];
        end
    end

    // ---------------- descriptor memory ----------------
    assign mem_we    = req_fire && (req.req_type == REQ_LOAD) && (32'(req.slot) < MAX_FIELDS);
    assign mem_waddr = PW'(req.slot);
    assign mem_wdata = '{kind:         req.kind,
                         size_bytes:   req.size_bytes,
                         bound_low:    req.bound_low,
                         bound_high:   req.bound_high,
                         match_first:  req.match_first,
                         match_second: req.match_second,
                         match_count:  req.match_count};

    // Port A: position as it stands; port B: where the word in stage 1 may move it.
    assign rd_a_addr = field_pos_reg;
    assign rd_b_addr = (s1_valid_reg && (s1_req_reg.req_type == REQ_RESTART)) ?
                       '0 : field_pos_reg + PW'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            desc_mem[mem_waddr] <= mem_wdata;
        end
        if (req_fire)
        begin
            rd_a_reg  <= desc_mem[rd_a_addr];
            rd_b_reg  <= desc_mem[rd_b_addr];
            sel_b_reg <= (field_pos_next != field_pos_reg);
            s1_req_reg <= req;
        end
        if (s1_fire)
        begin
            rsp_reg <= '{complete:  done,
                         stuck:     stuck_next,
                         field_now: 4'(field_pos_next)};
        end
    end

    // ---------------- field step ----------------
    assign cur = sel_b_reg ? rd_b_reg : rd_a_reg;

    always_comb
    begin
        if (cur.size_bytes == 8'd0)
        begin
            sz = 8'd1;
        end
        else
        begin
            sz = cur.size_bytes;
        end
        if (((cur.kind == KIND_INT) || (cur.kind == KIND_PREFIX)) &&
            (sz > 8'(MAX_PREFIX_BYTES)))
        begin
            sz = 8'(MAX_PREFIX_BYTES);
        end
    end

    always_comb
    begin
        if (field_total_reg == 5'd0)
        begin
            total_eff = TW'(1);
        end
        else if (32'(field_total_reg) > MAX_FIELDS)
        begin
            total_eff = TW'(MAX_FIELDS);
        end
        else
        begin
            total_eff = TW'(field_total_reg);
        end
    end

    assign last_pos = PW'(total_eff - TW'(1));

    always_comb
    begin
        field_pos_next    = field_pos_reg;
        head_count_next   = head_count_reg;
        head_value_next   = head_value_reg;
        length_known_next = length_known_reg;
        body_count_next   = body_count_reg;
        stuck_next        = stuck_reg;
        verdict           = VERD_PENDING;
        done              = 1'b0;
        alive             = 2'b00;
        cb_k              = sz - 8'd1 - head_count_reg;
        hv_new            = {head_value_reg[23:0], s1_req_reg.data_byte};
        hc_inc            = head_count_reg + 8'd1;
        shb               = 2'(sz - hc_inc);
        mn                = 57'(hv_new) << {shb, 3'b000};
        mx                = (57'(hv_new) + 57'd1) << {shb, 3'b000};
        hdr_verdict       = VERD_PENDING;

        // Header verdict for integers and length prefixes
        if (hc_inc < sz)
        begin
            if ((57'(cur.bound_high) <= mn) || (mx <= 57'(cur.bound_low)))
            begin
                hdr_verdict = VERD_STUCK;
            end
        end
        else if ((cur.bound_low <= hv_new) && (33'(hv_new) < cur.bound_high))
        begin
            hdr_verdict = VERD_VALID;
        end
        else
        begin
            hdr_verdict = VERD_STUCK;
        end

        if (s1_fire)
        begin
            case (s1_req_reg.req_type)
                REQ_RESTART:
                begin
                    field_pos_next    = '0;
                    head_count_next   = 8'd0;
                    head_value_next   = 32'd0;
                    length_known_next = 1'b0;
                    body_count_next   = 33'd0;
                    stuck_next        = 1'b0;
                end
                REQ_DATA:
                begin
                    if (!stuck_reg)
                    begin
                        case (cur.kind)
                            KIND_CONST:
                            begin
                                if (head_count_reg >= sz)
                                begin
                                    verdict = VERD_STUCK;
                                end
                                else
                                begin
                                    if (head_count_reg == 8'd0)
                                    begin
                                        alive = {cur.match_count[1], 1'b1};
                                    end
                                    else
                                    begin
                                        alive = head_value_reg[1:0];
                                    end
                                    if (const_byte(cur.match_first, cb_k) !=
                                        s1_req_reg.data_byte)
                                    begin
                                        alive[0] = 1'b0;
                                    end
                                    if (const_byte(cur.match_second, cb_k) !=
                                        s1_req_reg.data_byte)
                                    begin
                                        alive[1] = 1'b0;
                                    end
                                    // mask of constants still matching
                                    if (head_count_reg == 8'd0)
                                    begin
                                        head_value_next = {30'd0, alive};
                                    end
                                    else
                                    begin
                                        head_value_next = {head_value_reg[31:2], alive};
                                    end
                                    head_count_next = hc_inc;
                                    if (alive == 2'b00)
                                    begin
                                        verdict = VERD_STUCK;
                                    end
                                    else if (hc_inc == sz)
                                    begin
                                        verdict = VERD_VALID;
                                    end
                                end
                            end
                            KIND_FIXED:
                            begin
                                if (body_count_reg >= 33'(sz))
                                begin
                                    verdict = VERD_STUCK;
                                end
                                else
                                begin
                                    body_count_next = body_count_reg + 33'd1;
                                    if (body_count_next == 33'(sz))
                                    begin
                                        verdict = VERD_VALID;
                                    end
                                end
                            end
                            default:
                            begin
                                if ((cur.kind == KIND_INT) || !length_known_reg)
                                begin
                                    if (head_count_reg >= sz)
                                    begin
                                        verdict = VERD_STUCK;
                                    end
                                    else
                                    begin
                                        head_value_next = hv_new;
                                        head_count_next = hc_inc;
                                        if ((cur.kind == KIND_INT) ||
                                            (hdr_verdict != VERD_VALID))
                                        begin
                                            verdict = hdr_verdict;
                                        end
                                        else
                                        begin
                                            length_known_next = 1'b1;
                                            verdict = (hv_new == 32'd0) ?
                                                      VERD_VALID : VERD_PENDING;
                                        end
                                    end
                                end
                                else if (body_count_reg >= 33'(head_value_reg))
                                begin
                                    verdict = VERD_STUCK;
                                end
                                else
                                begin
                                    body_count_next = body_count_reg + 33'd1;
                                    if (body_count_next == 33'(head_value_reg))
                                    begin
                                        verdict = VERD_VALID;
                                    end
                                end
                            end
                        endcase

                        case (verdict)
                            VERD_STUCK:
                            begin
                                stuck_next = 1'b1;
                            end
                            VERD_VALID:
                            begin
                                if (field_pos_reg >= last_pos)
                                begin
                                    done = 1'b1;
                                end
                                else
                                begin
                                    field_pos_next    = field_pos_reg + PW'(1);
                                    head_count_next   = 8'd0;
                                    head_value_next   = 32'd0;
                                    length_known_next = 1'b0;
                                    body_count_next   = 33'd0;
                                end
                            end
                            default:
                            begin
                                done = 1'b0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    done = 1'b0;
                end
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            field_pos_reg    <= '0;
            head_count_reg   <= 8'd0;
            head_value_reg   <= 32'd0;
            length_known_reg <= 1'b0;
            body_count_reg   <= 33'd0;
            stuck_reg        <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            field_pos_reg    <= field_pos_next;
            head_count_reg   <= head_count_next;
            head_value_reg   <= head_value_next;
            length_known_reg <= length_known_next;
            body_count_reg   <= body_count_next;
            stuck_reg        <= stuck_next;
        end
    end

    // ---------------- assertions ----------------
    `TVSV_ASSERT_NEXT(a_stuck_sticky,
        s1_fire && stuck_reg && (s1_req_reg.req_type != REQ_RESTART),
        stuck_reg,
        "stuck flag dropped without a restart")

    `TVSV_ASSERT_NEXT(a_pos_single_step,
        s1_fire && (s1_req_reg.req_type == REQ_DATA),
        (field_pos_reg == $past(field_pos_reg)) ||
        (field_pos_reg == ($past(field_pos_reg) + PW'(1))),
        "data byte moved the field position by more than one")

    `TVSV_ASSERT_NEXT(a_restart_clears,
        s1_fire && (s1_req_reg.req_type == REQ_RESTART),
        (field_pos_reg == '0) && !stuck_reg && (head_count_reg == 8'd0) &&
        (body_count_reg == 33'd0),
        "restart left parse state behind")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the schema validator core: queued stimulus, handshake driver, result checker.
module tb;
    import tvsv_pkg::*;

    localparam int         NUM_SLOTS        = 16;
    localparam logic [1:0] REQ_NOP          = 2'd3;   // spare request code, must change nothing
    localparam logic [2:0] ADDR_FIELD_TOTAL = 3'd0;
    localparam int         QUIET_LIMIT      = 2000;
    localparam int         PHASE_WORDS      = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_word_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_word_t   rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    tls_vector_schema_validator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    // parser state as the checker sees it
    desc_t           schema_q [NUM_SLOTS];
    logic [3:0]      pos_q    = '0;
    int unsigned     hdr_cnt  = 0;
    logic [31:0]     hdr_val  = '0;
    bit              len_seen = 1'b0;
    longint unsigned body_cnt = 0;
    bit              stuck_q  = 1'b0;
    logic [4:0]      total_q  = 5'd1;
    rsp_word_t       expected_status [$];

    // stimulus side: its own copy of the loaded schema
    desc_t           plan_tab [NUM_SLOTS];
    int unsigned     plan_fields = 1;
    req_word_t       send_q [$];

    int          stim_words  = 0;
    int          words_in    = 0;
    int          results_in  = 0;
    int          bad_status  = 0;
    int          completes   = 0;
    int          stuck_seen  = 0;
    int          cfg_writes  = 0;
    int          quiet       = 0;
    int          burst_left  = 0;
    int          gap_left    = 0;
    logic [15:0] stall_pat   = 16'hffff;
    logic [3:0]  pat_pos     = '0;
    rsp_word_t   status_want;
    int          phase_mark;
    logic [4:0]  totals [9]  = '{5'd16, 5'd0, 5'd9, 5'd31, 5'd3, 5'd17, 5'd1, 5'd5, 5'd12};

    function automatic logic [7:0] set_byte(input logic [15:0] v, input int unsigned sz,
                                            input int unsigned j);
        int unsigned k;
        k = sz - 1 - j;
        if (k >= SET_BYTES) return 8'h00;
        return v[8*k +: 8];
    endfunction

    function automatic void clear_progress();
        hdr_cnt  = 0;
        hdr_val  = '0;
        len_seen = 1'b0;
        body_cnt = 0;
    endfunction

    // can the partial big-endian value still land in [lo, hi)?
    function automatic verdict_t span_verdict(input longint unsigned v, input int unsigned cnt,
                                              input int unsigned n, input longint unsigned lo,
                                              input longint unsigned hi);
        longint unsigned lo_end;
        longint unsigned hi_end;
        if (cnt < n)
        begin
            lo_end = v << (8 * (n - cnt));
            hi_end = (v + 1) << (8 * (n - cnt));
            if (hi <= lo_end || hi_end <= lo) return VERD_STUCK;
            return VERD_PENDING;
        end
        if (lo <= v && v < hi) return VERD_VALID;
        return VERD_STUCK;
    endfunction

    function automatic verdict_t step_field(input desc_t d, input logic [7:0] b);
        int unsigned     sz;
        longint unsigned lo;
        longint unsigned hi;
        verdict_t        vd;
        sz = (d.size_bytes == 0) ? 1 : d.size_bytes;
        lo = d.bound_low;
        hi = d.bound_high;
        if ((d.kind == KIND_INT || d.kind == KIND_PREFIX) && sz > MAX_PREFIX_BYTES)
            sz = MAX_PREFIX_BYTES;
        case (kind_code_t'(d.kind))
            KIND_CONST:
            begin
                if (hdr_cnt >= sz) return VERD_STUCK;
                // hdr_val holds the mask of candidate constants still alive
                if (hdr_cnt == 0) hdr_val = (d.match_count >= 2) ? 32'd3 : 32'd1;
                if (set_byte(d.match_first, sz, hdr_cnt) != b) hdr_val[0] = 1'b0;
                if (set_byte(d.match_second, sz, hdr_cnt) != b) hdr_val[1] = 1'b0;
                hdr_cnt++;
                if (hdr_val[1:0] == 2'b00) return VERD_STUCK;
                if (hdr_cnt == sz) return VERD_VALID;
                return VERD_PENDING;
            end
            KIND_FIXED:
            begin
                if (body_cnt >= sz) return VERD_STUCK;
                body_cnt++;
                if (body_cnt == sz) return VERD_VALID;
                return VERD_PENDING;
            end
            default:
            begin
                if (d.kind == KIND_INT || !len_seen)
                begin
                    if (hdr_cnt >= sz) return VERD_STUCK;
                    hdr_val = {hdr_val[23:0], b};
                    hdr_cnt++;
                    vd = span_verdict(hdr_val, hdr_cnt, sz, lo, hi);
                    if (d.kind == KIND_INT || vd != VERD_VALID) return vd;
                    len_seen = 1'b1;
                    if (hdr_val == 0) return VERD_VALID;
                    return VERD_PENDING;
                end
                if (body_cnt >= hdr_val) return VERD_STUCK;
                body_cnt++;
                if (body_cnt == hdr_val) return VERD_VALID;
                return VERD_PENDING;
            end
        endcase
        return VERD_STUCK;
    endfunction

    function automatic rsp_word_t predict_status(input req_word_t w);
        rsp_word_t   r;
        int unsigned used;
        verdict_t    vd;
        r.complete = 1'b0;
        case (w.req_type)
            REQ_LOAD:
                schema_q[w.slot] = {w.kind, w.size_bytes, w.bound_low, w.bound_high,
                                    w.match_first, w.match_second, w.match_count};
            REQ_RESTART:
            begin
                pos_q   = '0;
                stuck_q = 1'b0;
                clear_progress();
            end
            REQ_DATA:
            begin
                if (!stuck_q)
                begin
                    used = (total_q == 0) ? 1 : ((total_q > NUM_SLOTS) ? NUM_SLOTS : total_q);
                    vd = step_field(schema_q[pos_q], w.data_byte);
                    if (vd == VERD_STUCK)
                        stuck_q = 1'b1;
                    else if (vd == VERD_VALID)
                    begin
                        // a position past the last field counts as the last one
                        if (pos_q >= used - 1)
                            r.complete = 1'b1;
                        else
                        begin
                            pos_q++;
                            clear_progress();
                        end
                    end
                end
            end
            default: ;
        endcase
        r.stuck     = stuck_q;
        r.field_now = pos_q;
        return r;
    endfunction

    function automatic req_word_t noise_word(input logic [1:0] code);
        req_word_t    w;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(req_word_t)-1:0];
        w.req_type = code;
        return w;
    endfunction

    function automatic void queue_code(input logic [1:0] code);
        send_q.push_back(noise_word(code));
        stim_words++;
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        req_word_t w;
        w = noise_word(REQ_DATA);
        w.data_byte = b;
        send_q.push_back(w);
        stim_words++;
    endfunction

    function automatic void queue_load(input logic [3:0] slot, input desc_t d);
        req_word_t w;
        w = noise_word(REQ_LOAD);
        w.slot = slot;
        {w.kind, w.size_bytes, w.bound_low, w.bound_high,
         w.match_first, w.match_second, w.match_count} = d;
        plan_tab[slot] = d;
        send_q.push_back(w);
        stim_words++;
    endfunction

    function automatic desc_t mk_desc(input kind_code_t k, input logic [7:0] sz,
                                      input logic [31:0] lo, input logic [32:0] hi,
                                      input logic [15:0] a, input logic [15:0] b,
                                      input logic [1:0] cnt);
        desc_t d;
        d.kind         = k;
        d.size_bytes   = sz;
        d.bound_low    = lo;
        d.bound_high   = hi;
        d.match_first  = a;
        d.match_second = b;
        d.match_count  = cnt;
        return d;
    endfunction

    // mostly satisfiable descriptors with small sizes; now and then odd sizes and wild bounds
    function automatic desc_t rand_desc();
        desc_t           d;
        int unsigned     n;
        int unsigned     roll;
        longint unsigned top;
        d.kind         = 2'($urandom_range(0, 3));
        d.match_first  = 16'($urandom);
        d.match_second = 16'($urandom);
        d.match_count  = 2'($urandom_range(0, 3));
        d.bound_low    = $urandom;
        d.bound_high   = {1'($urandom), $urandom};
        roll = $urandom_range(0, 7);
        case (kind_code_t'(d.kind))
            KIND_CONST:
                d.size_bytes = (roll == 0) ? 8'd0 :
                               (roll == 1) ? 8'($urandom_range(3, 200)) :
                                             8'($urandom_range(1, 2));
            KIND_INT:
            begin
                n = (roll == 1) ? 1 : $urandom_range(1, 4);
                top = 64'd1 << (8 * n);
                d.size_bytes = (roll == 0) ? 8'($urandom_range(5, 255)) :
                               (roll == 1) ? 8'd0 : 8'(n);
                if (roll >= 1 && roll <= 5)
                begin
                    d.bound_low  = 32'($urandom % top);
                    d.bound_high = 33'(d.bound_low) + 33'($urandom_range(1, 300));
                end
                else if (roll == 6)
                begin
                    d.bound_low  = '0;
                    d.bound_high = 33'h1_0000_0000;
                end
            end
            KIND_PREFIX:
            begin
                d.size_bytes = (roll == 0) ? 8'd0 :
                               (roll == 1) ? 8'($urandom_range(5, 255)) :
                                             8'($urandom_range(1, 2));
                if (roll <= 5)
                begin
                    d.bound_low  = $urandom_range(0, 3);
                    d.bound_high = 33'(d.bound_low) + 33'($urandom_range(1, 6));
                end
                else if (roll == 6)
                begin
                    d.bound_low  = '0;
                    d.bound_high = 33'h1_0000_0000;
                end
            end
            default:
                d.size_bytes = (roll == 0) ? 8'd0 :
                               (roll == 1 && $urandom_range(0, 3) == 0) ?
                                   8'($urandom_range(128, 160)) :
                                   8'($urandom_range(1, 6));
        endcase
        return d;
    endfunction

    // bytes that satisfy one field, where the descriptor allows it
    function automatic void field_bytes(input desc_t d, ref logic [7:0] q[$]);
        int unsigned     sz;
        int unsigned     n;
        int unsigned     len;
        logic [15:0]     cv;
        longint unsigned top;
        longint unsigned ub;
        longint unsigned lo;
        longint unsigned v;
        longint unsigned span;
        sz  = (d.size_bytes == 0) ? 1 : d.size_bytes;
        n   = (sz > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : sz;
        top = 64'd1 << (8 * n);
        lo  = d.bound_low;
        ub  = (d.bound_high < top) ? d.bound_high : top;
        case (kind_code_t'(d.kind))
            KIND_CONST:
            begin
                cv = (d.match_count >= 2 && $urandom_range(0, 1) == 1) ?
                     d.match_second : d.match_first;
                for (int j = 0; j < sz; j++) q.push_back(set_byte(cv, sz, j));
            end
            KIND_INT:
            begin
                if (lo < ub) v = lo + ({$urandom, $urandom} % (ub - lo));
                else v = {32'd0, $urandom};
                for (int j = n - 1; j >= 0; j--) q.push_back(v[8*j +: 8]);
            end
            KIND_PREFIX:
            begin
                if (lo < ub && lo <= 40)
                begin
                    span = ub - lo - 1;
                    if (span > 6) span = 6;
                    len = 32'(lo) + $urandom_range(0, 32'(span));
                end
                else
                    len = $urandom_range(0, 3);
                v = len;
                for (int j = n - 1; j >= 0; j--) q.push_back(v[8*j +: 8]);
                repeat (len) q.push_back(8'($urandom));
            end
            default:
                repeat (sz) q.push_back(8'($urandom));
        endcase
    endfunction

    // one restart plus a message for the current schema; sometimes damaged
    function automatic void queue_parse(input bit partial);
        logic [7:0]  bytes_q [$];
        int unsigned n_fields;
        int unsigned pick;
        int unsigned idx;
        n_fields = partial ? plan_fields - 1 : plan_fields;
        queue_code(REQ_RESTART);
        for (int f = 0; f < n_fields; f++) field_bytes(plan_tab[f], bytes_q);
        pick = $urandom_range(0, 9);
        if (!partial && bytes_q.size() > 0)
        begin
            if (pick == 7)
            begin
                idx = $urandom_range(0, bytes_q.size() - 1);
                bytes_q[idx] = bytes_q[idx] ^ 8'($urandom_range(1, 255));
            end
            else if (pick == 8)
                repeat ($urandom_range(1, bytes_q.size())) void'(bytes_q.pop_back());
            else if (pick == 9)
                bytes_q.push_back(8'($urandom));   // trailing byte after completion
        end
        foreach (bytes_q[i])
        begin
            if ($urandom_range(0, 24) == 0) queue_code(REQ_NOP);
            queue_byte(bytes_q[i]);
        end
    endfunction

    task automatic wait_idle();
        while (send_q.size() != 0 || req_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_field_total(input logic [4:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FIELD_TOTAL;
        pwdata  <= {27'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        total_q = v;
        plan_fields = (v == 0) ? 1 : ((v > NUM_SLOTS) ? NUM_SLOTS : v);
        cfg_writes++;
        @(negedge clk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_status.push_back(predict_status(req));
                words_in++;
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    req       <= send_q.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: ready follows a 16-bit pattern, redrawn each time round, never all low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_pat <= 16'hffff;
            pat_pos   <= '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                results_in++;
                if (expected_status.size() == 0)
                begin
                    bad_status++;
                    if (bad_status <= 10)
                        $display("%0t: result word with nothing outstanding: %p", $realtime, rsp);
                end
                else
                begin
                    status_want = expected_status.pop_front();
                    if (rsp.complete !== status_want.complete || rsp.stuck !== status_want.stuck
                        || rsp.field_now !== status_want.field_now)
                    begin
                        bad_status++;
                        if (bad_status <= 10)
                            $display("%0t: mismatch exp complete=%0b stuck=%0b field=%0d, got %0b %0b %0d",
                                     $realtime, status_want.complete, status_want.stuck,
                                     status_want.field_now, rsp.complete, rsp.stuck, rsp.field_now);
                    end
                end
                if (rsp.complete === 1'b1) completes++;
                if (rsp.stuck === 1'b1) stuck_seen++;
            end
            rsp_ready <= stall_pat[pat_pos];
            pat_pos   <= pat_pos + 4'd1;
            if (pat_pos == 4'd15)
                stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full table first so that no byte ever reaches an empty slot
        queue_load(4'd0, mk_desc(KIND_CONST, 8'd2, 32'd0, 33'd0, 16'hABCD, 16'h1234, 2'd2));
        queue_load(4'd1, mk_desc(KIND_INT, 8'd5, 32'd0, 33'h1_0000_0000, 16'd0, 16'd0, 2'd1));
        queue_load(4'd2, mk_desc(KIND_PREFIX, 8'd1, 32'd0, 33'd4, 16'd0, 16'd0, 2'd1));
        queue_load(4'd3, mk_desc(KIND_FIXED, 8'd0, 32'd0, 33'd0, 16'd0, 16'd0, 2'd1));
        queue_load(4'd4, mk_desc(KIND_CONST, 8'd0, 32'd0, 33'd0, 16'h00FF, 16'hFF00, 2'd0));
        queue_load(4'd5, mk_desc(KIND_CONST, 8'd3, 32'd0, 33'd0, 16'hFFFF, 16'h0000, 2'd3));
        queue_load(4'd6, mk_desc(KIND_INT, 8'd4, 32'hFFFF_FFFF, 33'h1_0000_0000,
                                 16'd0, 16'd0, 2'd1));
        queue_load(4'd7, mk_desc(KIND_FIXED, 8'd140, 32'd0, 33'd0, 16'd0, 16'd0, 2'd1));
        queue_load(4'd8, mk_desc(KIND_PREFIX, 8'd255, 32'd1, 33'd3, 16'd0, 16'd0, 2'd1));
        for (int s = 9; s < NUM_SLOTS; s++) queue_load(4'(s), rand_desc());
        // one-field schema: match, a byte too many, a byte while stuck, then a bad constant
        queue_byte(8'hAB);
        queue_byte(8'hCD);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_code(REQ_NOP);
        queue_code(REQ_RESTART);
        queue_byte(8'h12);
        queue_byte(8'h30);
        queue_code(REQ_RESTART);

        foreach (totals[p])
        begin
            wait_idle();
            write_field_total(totals[p]);
            // these continue wherever the previous phase left the parser
            queue_byte(8'($urandom));
            queue_byte(8'($urandom));
            repeat ($urandom_range(1, 4)) queue_load(4'($urandom_range(0, 15)), rand_desc());
            phase_mark = stim_words;
            while (stim_words - phase_mark < PHASE_WORDS)
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_load(4'($urandom_range(0, 15)), rand_desc());
                else
                    queue_parse(1'b0);
            end
            // stop one field short so the next setting may find the parser past its end
            queue_parse(1'b1);
        end

        wait_idle();
        $display("Run: %0d words sent, %0d results checked, %0d with complete, %0d with stuck",
                 words_in, results_in, completes, stuck_seen);
        $display("Schema depth changed %0d times, covering 0, 1, 16, 17 and 31", cfg_writes);
        if (bad_status == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
